FILE: rtl/fsbe_pkg.sv
// shared types and constants for the fixed string buffer editor
package fsbe_pkg;

	localparam int DEF_CAPACITY = 128;

	localparam logic [7:0] NOT_FOUND = 8'hFF;

	typedef enum logic [2:0] {
		OP_CLEAR_TEXT  = 3'd0,
		OP_APPEND_TEXT = 3'd1,
		OP_CLEAR_PAT   = 3'd2,
		OP_APPEND_PAT  = 3'd3,
		OP_INSERT      = 3'd4,
		OP_DELETE      = 3'd5,
		OP_SEARCH      = 3'd6,
		OP_READ        = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_INS_SHIFT,
		ST_INS_COPY,
		ST_DEL_SHIFT,
		ST_SRCH,
		ST_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_req;
		logic exec;
		logic ins_shift;
		logic ins_copy;
		logic del_shift;
		logic srch_step;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		op_t  op;
		logic ins_ok;
		logic del_ok;
		logic srch_go;
		logic shift_more;
		logic copy_more;
		logic del_more;
		logic srch_hit;
		logic srch_end;
		logic out_free;
	} sts_t;

endpackage

FILE: rtl/fsbe_ctrl.sv
// sequencing state machine of the fixed string buffer editor
module fsbe_ctrl import fsbe_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				unique case (sts.op)
					OP_INSERT: state_d = sts.ins_ok ? ST_INS_SHIFT : ST_FINISH;
					OP_DELETE: state_d = sts.del_ok ? ST_DEL_SHIFT : ST_FINISH;
					OP_SEARCH: state_d = sts.srch_go ? ST_SRCH : ST_FINISH;
					default:   state_d = ST_FINISH;
				endcase
			end
			ST_INS_SHIFT: begin
				if (!sts.shift_more) state_d = ST_INS_COPY;
			end
			ST_INS_COPY: begin
				if (!sts.copy_more) state_d = ST_FINISH;
			end
			ST_DEL_SHIFT: begin
				if (!sts.del_more) state_d = ST_FINISH;
			end
			ST_SRCH: begin
				if (sts.srch_hit || sts.srch_end) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load_req = in_valid;
			end
			ST_EXEC:      cmd.exec = 1'b1;
			ST_INS_SHIFT: cmd.ins_shift = 1'b1;
			ST_INS_COPY:  cmd.ins_copy = 1'b1;
			ST_DEL_SHIFT: cmd.del_shift = 1'b1;
			ST_SRCH:      cmd.srch_step = 1'b1;
			ST_FINISH:    cmd.finish = sts.out_free;
			default:      cmd = '0;
		endcase
	end

endmodule

FILE: rtl/fsbe_datapath.sv
// text and pattern memories, lengths, index counters and result register
module fsbe_datapath import fsbe_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic [2:0]        operation,
	input  logic [7:0]        position,
	input  logic [7:0]        count,
	input  logic [7:0]        char_in,
	input  logic              out_stall,
	output logic              out_valid,
	output logic              ok,
	output logic signed [7:0] found_index,
	output logic [7:0]        length_now,
	output logic [7:0]        char_out
);

	localparam int LW = $clog2(CAPACITY + 1);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int XW = ((LW > 8) ? LW : 8) + 1;
	localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);

	logic [7:0] text_mem [CAPACITY];
	logic [7:0] pat_mem [CAPACITY];

	op_t         op_q;
	logic [7:0]  pos_q;
	logic [7:0]  cnt_q;
	logic [7:0]  chr_q;
	logic [LW-1:0] tlen_q;
	logic [LW-1:0] plen_q;
	logic [LW-1:0] tlen_d;
	logic [LW-1:0] plen_d;
	logic [XW-1:0] idx_q;
	logic [XW-1:0] lim_q;
	logic [LW-1:0] sub_q;
	logic        res_ok_q;
	logic [7:0]  res_found_q;
	logic [7:0]  text_rd_q;
	logic [7:0]  pat_rd_q;
	logic        wr_pend_s1;
	logic [AW-1:0] wr_addr_s1;
	logic        wr_pat_s1;
	logic        out_valid_q;
	logic        out_ok_q;
	logic [7:0]  out_found_q;
	logic [7:0]  out_len_q;
	logic [7:0]  out_char_q;

	logic [XW-1:0] pos_x, cnt_x, tlen_x, plen_x, sub_x;
	logic [XW-1:0] sum_pp, sum_pc, sum_tp, new_len, del_len, next_s;
	logic          rd_ok, app_t_ok, app_p_ok;
	logic          match, last, fits;
	logic          ins_step, copy_step, del_step;
	logic          text_re, pat_re, text_we;
	logic [XW-1:0] text_ra, pat_ra;
	logic [AW-1:0] text_wa;
	logic [7:0]    text_wd;

	assign pos_x  = XW'(pos_q);
	assign cnt_x  = XW'(cnt_q);
	assign tlen_x = XW'(tlen_q);
	assign plen_x = XW'(plen_q);
	assign sub_x  = XW'(sub_q);
	assign sum_pp = pos_x + plen_x;
	assign sum_pc = pos_x + cnt_x;
	assign sum_tp = tlen_x + plen_x;
	assign new_len = (sum_tp > CAP_X) ? CAP_X : sum_tp;
	assign del_len = tlen_x - cnt_x;
	assign next_s  = idx_q + XW'(1);

	assign rd_ok    = pos_x < tlen_x;
	assign app_t_ok = tlen_x < CAP_X;
	assign app_p_ok = plen_x < CAP_X;

	// brute force compare of the pair fetched last cycle
	assign match = text_rd_q == pat_rd_q;
	assign last  = (sub_x + XW'(1)) == plen_x;
	assign fits  = (next_s + plen_x) <= tlen_x;

	always_comb begin
		sts            = '0;
		sts.op         = op_q;
		sts.ins_ok     = pos_x <= tlen_x;
		sts.del_ok     = sum_pc <= tlen_x;
		sts.srch_go    = (plen_q != '0) && (sum_pp <= tlen_x);
		sts.shift_more = idx_q > lim_q;
		sts.copy_more  = (sub_q < plen_q) && ((pos_x + sub_x) < CAP_X);
		sts.del_more   = idx_q < lim_q;
		sts.srch_hit   = match && last;
		sts.srch_end   = !match && !fits;
		sts.out_free   = !out_valid_q || !out_stall;
	end

	assign ins_step  = cmd.ins_shift && sts.shift_more;
	assign copy_step = cmd.ins_copy && sts.copy_more;
	assign del_step  = cmd.del_shift && sts.del_more;

	// read port selection
	always_comb begin
		text_re = 1'b0;
		pat_re  = 1'b0;
		text_ra = '0;
		pat_ra  = '0;
		if (cmd.exec) begin
			if (op_q == OP_READ) begin
				text_re = rd_ok;
				text_ra = pos_x;
			end else if (op_q == OP_SEARCH) begin
				text_re = sts.srch_go;
				pat_re  = sts.srch_go;
				text_ra = pos_x;
			end
		end else if (ins_step) begin
			text_re = 1'b1;
			text_ra = idx_q - XW'(1) - plen_x;
		end else if (copy_step) begin
			pat_re = 1'b1;
			pat_ra = sub_x;
		end else if (del_step) begin
			text_re = 1'b1;
			text_ra = idx_q;
		end else if (cmd.srch_step) begin
			if (match && !last) begin
				text_re = 1'b1;
				pat_re  = 1'b1;
				text_ra = idx_q + sub_x + XW'(1);
				pat_ra  = sub_x + XW'(1);
			end else if (!match && fits) begin
				text_re = 1'b1;
				pat_re  = 1'b1;
				text_ra = next_s;
			end
		end
	end

	// write port: a delayed move or an append
	assign text_we = wr_pend_s1 || (cmd.exec && op_q == OP_APPEND_TEXT && app_t_ok);
	assign text_wa = wr_pend_s1 ? wr_addr_s1 : tlen_q[AW-1:0];
	assign text_wd = wr_pend_s1 ? (wr_pat_s1 ? pat_rd_q : text_rd_q) : chr_q;

	always_ff @(posedge clk) begin
		if (text_we) text_mem[text_wa] <= text_wd;
		if (text_re) text_rd_q <= text_mem[text_ra[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && op_q == OP_APPEND_PAT && app_p_ok) pat_mem[plen_q[AW-1:0]] <= chr_q;
		if (pat_re) pat_rd_q <= pat_mem[pat_ra[AW-1:0]];
	end

	// length updates
	always_comb begin
		tlen_d = tlen_q;
		plen_d = plen_q;
		if (cmd.exec) begin
			unique case (op_q)
				OP_CLEAR_TEXT:  tlen_d = '0;
				OP_APPEND_TEXT: if (app_t_ok) tlen_d = tlen_q + LW'(1);
				OP_CLEAR_PAT:   plen_d = '0;
				OP_APPEND_PAT:  if (app_p_ok) plen_d = plen_q + LW'(1);
				OP_INSERT:      if (sts.ins_ok) tlen_d = new_len[LW-1:0];
				OP_DELETE:      if (sts.del_ok) tlen_d = del_len[LW-1:0];
				default:        tlen_d = tlen_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tlen_q      <= '0;
			plen_q      <= '0;
			wr_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			tlen_q     <= tlen_d;
			plen_q     <= plen_d;
			wr_pend_s1 <= ins_step || copy_step || del_step;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			op_q  <= op_t'(operation);
			pos_q <= position;
			cnt_q <= count;
			chr_q <= char_in;
		end
		if (cmd.exec) begin
			res_found_q <= NOT_FOUND;
			unique case (op_q)
				OP_APPEND_TEXT: res_ok_q <= app_t_ok;
				OP_APPEND_PAT:  res_ok_q <= app_p_ok;
				OP_INSERT: begin
					res_ok_q <= sts.ins_ok;
					idx_q    <= new_len;
					lim_q    <= sum_pp;
					sub_q    <= '0;
				end
				OP_DELETE: begin
					res_ok_q <= sts.del_ok;
					idx_q    <= sum_pc;
					lim_q    <= tlen_x;
				end
				OP_SEARCH: begin
					res_ok_q <= 1'b1;
					if (plen_q == '0) res_found_q <= '0;
					idx_q <= pos_x;
					sub_q <= '0;
				end
				OP_READ: res_ok_q <= rd_ok;
				default: res_ok_q <= 1'b1;
			endcase
		end
		if (ins_step) begin
			idx_q      <= idx_q - XW'(1);
			wr_addr_s1 <= AW'(idx_q - XW'(1));
			wr_pat_s1  <= 1'b0;
		end
		if (copy_step) begin
			sub_q      <= sub_q + LW'(1);
			wr_addr_s1 <= AW'(pos_x + sub_x);
			wr_pat_s1  <= 1'b1;
		end
		if (del_step) begin
			idx_q      <= next_s;
			wr_addr_s1 <= AW'(idx_q - cnt_x);
			wr_pat_s1  <= 1'b0;
		end
		if (cmd.srch_step) begin
			if (match && last) begin
				res_found_q <= idx_q[7:0];
			end else if (match) begin
				sub_q <= sub_q + LW'(1);
			end else if (fits) begin
				idx_q <= next_s;
				sub_q <= '0;
			end
		end
		if (cmd.finish) begin
			out_ok_q    <= res_ok_q;
			out_found_q <= res_found_q;
			out_len_q   <= tlen_x[7:0];
			out_char_q  <= (op_q == OP_READ && res_ok_q) ? text_rd_q : 8'd0;
		end
	end

	assign out_valid   = out_valid_q;
	assign ok          = out_ok_q;
	assign found_index = signed'(out_found_q);
	assign length_now  = out_len_q;
	assign char_out    = out_char_q;

endmodule

FILE: rtl/fixed_string_buffer_editor.sv
// top level of the fixed string buffer editor
// text and pattern buffers of CAPACITY bytes, each in a memory with one write and one
// registered read port; one request in flight at a time, its result held in an output
// register so the next request is taken while the result waits. insert moves the tail
// characters up and then copies in the pattern characters, delete moves the characters
// after the deleted span down; each moved character costs one cycle of the text read
// port. search makes one text/pattern byte compare per cycle in a brute force scan.
module fixed_string_buffer_editor import fsbe_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic              clk,
	input  logic              arst_n,
	// request channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        operation,
	input  logic [7:0]        position,
	input  logic [7:0]        count,
	input  logic [7:0]        char_in,
	// result channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic              ok,
	output logic signed [7:0] found_index,
	output logic [7:0]        length_now,
	output logic [7:0]        char_out
);

	cmd_t cmd;
	sts_t sts;

	// state machine: accepts a request, runs the shift, copy or scan, then posts the result
	fsbe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// memories, lengths, counters and output register
	fsbe_datapath #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.operation   (operation),
		.position    (position),
		.count       (count),
		.char_in     (char_in),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.ok          (ok),
		.found_index (found_index),
		.length_now  (length_now),
		.char_out    (char_out)
	);

endmodule

FILE: rtl/fsbe_checker.sv
// port level checks for the fixed string buffer editor
module fsbe_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic [2:0]        operation,
	input logic [7:0]        position,
	input logic [7:0]        count,
	input logic [7:0]        char_in,
	input logic              out_valid,
	input logic              out_stall,
	input logic              ok,
	input logic signed [7:0] found_index,
	input logic [7:0]        length_now,
	input logic [7:0]        char_out
);

	// a stalled request stays put
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(operation) && $stable(position)
			&& $stable(count) && $stable(char_in))
		else $error("request changed while stalled");

	// a held result does not change
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(ok) && $stable(found_index)
			&& $stable(length_now) && $stable(char_out))
		else $error("result changed while stalled");

	// one request at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while busy");

	// a search position comes only from an accepted search
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found_index != -8'sd1 |-> ok && char_out == 8'd0)
		else $error("found index on a refused or non-search result");

	// a read byte comes only from an accepted read
	a_char_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && char_out != 8'd0 |-> ok)
		else $error("read byte on a refused result");

endmodule

bind fixed_string_buffer_editor fsbe_checker u_fsbe_checker (.*);
